// ----- src/svoi_pkg.sv -----
// Shared types and constants for the sparse voxel octree insert block.
// No dependencies; svoi_eval, the top level and the testbench import this package.
package svoi_pkg;

  localparam int POOL_NODES  = 4096;
  localparam int IDX_W       = $clog2(POOL_NODES);
  localparam int COORD_W     = 16;
  localparam int DEPTH_W     = 5;
  localparam int COLOR_W     = 32;
  localparam int DEPTH_LIMIT = 20;
  localparam int CHILD_ROW_W = 8 * IDX_W;

  localparam logic [COLOR_W-1:0] CLEAR_COLOR      = 32'd300;
  localparam logic [COLOR_W-1:0] PLACEHOLDER_BASE = 32'd500;
  localparam logic [IDX_W-1:0]   LAST_NODE        = IDX_W'(POOL_NODES - 1);

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t xl;
    coord_t xh;
    coord_t yl;
    coord_t yh;
    coord_t zl;
    coord_t zh;
  } box_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } pos_t;

  typedef struct packed {
    logic [COLOR_W-1:0] color;
    logic [DEPTH_W-1:0] depth;
  } info_t;

  typedef logic [7:0][IDX_W-1:0] child_row_t;

  // Per-level evaluation of one node's box against the point
  typedef struct packed {
    logic       at_min;
    logic       in_box;
    logic [2:0] oct;
    box_t       child_box;
  } eval_t;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_CLEAR  = 2'd1,
    OP_READ   = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_STORED    = 3'd0,
    ST_OUTSIDE   = 3'd1,
    ST_POOL_FULL = 3'd2,
    ST_READ_DONE = 3'd3,
    ST_CLEARED   = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    CFG_X_LOW  = 3'd0,
    CFG_X_HIGH = 3'd1,
    CFG_Y_LOW  = 3'd2,
    CFG_Y_HIGH = 3'd3,
    CFG_Z_LOW  = 3'd4,
    CFG_Z_HIGH = 3'd5,
    CFG_MIN    = 3'd6,
    CFG_UNUSED = 3'd7
  } cfg_idx_t;

  typedef enum logic [4:0] {
    S_INIT = 5'b00001,
    S_IDLE = 5'b00010,
    S_RD   = 5'b00100,
    S_EV   = 5'b01000,
    S_CLR  = 5'b10000
  } state_t;

endpackage

// ----- src/svoi_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module svoi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/svoi_eval.sv -----
// Evaluates one octree node: leaf-size test, containment, octant and child box.
// Depends on svoi_pkg.
module svoi_eval import svoi_pkg::*; (
  input  box_t                bx,
  input  pos_t                p,
  input  logic [COORD_W-1:0]  min_size,
  output eval_t               ev
);

  logic signed [COORD_W:0] sx, sy, sz;
  logic signed [COORD_W:0] dx, dy, dz;
  logic [COORD_W:0]        ax, ay, az;
  coord_t                  mx, my, mz;

  always_comb begin
    sx = {bx.xl[COORD_W-1], bx.xl} + {bx.xh[COORD_W-1], bx.xh};
    sy = {bx.yl[COORD_W-1], bx.yl} + {bx.yh[COORD_W-1], bx.yh};
    sz = {bx.zl[COORD_W-1], bx.zl} + {bx.zh[COORD_W-1], bx.zh};
    // floor midpoint
    mx = sx[COORD_W:1];
    my = sy[COORD_W:1];
    mz = sz[COORD_W:1];
    dx = {bx.xh[COORD_W-1], bx.xh} - {bx.xl[COORD_W-1], bx.xl};
    dy = {bx.yh[COORD_W-1], bx.yh} - {bx.yl[COORD_W-1], bx.yl};
    dz = {bx.zh[COORD_W-1], bx.zh} - {bx.zl[COORD_W-1], bx.zl};
    ax = dx[COORD_W] ? (COORD_W+1)'(-dx) : dx;
    ay = dy[COORD_W] ? (COORD_W+1)'(-dy) : dy;
    az = dz[COORD_W] ? (COORD_W+1)'(-dz) : dz;

    ev.at_min = (ax <= {1'b0, min_size}) && (ay <= {1'b0, min_size}) &&
                (az <= {1'b0, min_size});
    ev.in_box = (p.x >= bx.xl) && (p.x <= bx.xh) && (p.y >= bx.yl) &&
                (p.y <= bx.yh) && (p.z >= bx.zl) && (p.z <= bx.zh);
    ev.oct[0] = p.x > mx;
    ev.oct[1] = p.y <= my;
    ev.oct[2] = p.z > mz;

    ev.child_box = bx;
    if (ev.oct[0]) ev.child_box.xl = mx; else ev.child_box.xh = mx;
    // y bit set takes the bottom half
    if (ev.oct[1]) ev.child_box.yh = my; else ev.child_box.yl = my;
    if (ev.oct[2]) ev.child_box.zl = mz; else ev.child_box.zh = mz;
  end

endmodule

// ----- src/sparse_voxel_octree_insert.sv -----
// Top level of the sparse voxel octree insert block: control, node memories, result register.
// Depends on svoi_pkg, svoi_ram and svoi_eval.
//
// One command at a time. After reset the block sweeps all 4096 nodes (busy high) to set
// their reset contents. Insert visits up to 21 nodes when the descent runs 20 levels below
// the root; each level is one read of the node memories (S_RD) followed by one
// evaluate/write step (S_EV). Read passes through the same read and evaluate states.
// Clear writes one node row per cycle, rows 0 through nodes_used. The result appears for
// one cycle with done high and cannot be held off; opcode 3 is taken and gives no result.
module sparse_voxel_octree_insert import svoi_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         opcode,
  input  logic signed [15:0] voxel_x,
  input  logic signed [15:0] voxel_y,
  input  logic signed [15:0] voxel_z,
  input  logic [31:0]        voxel_color,
  input  logic [11:0]        read_index,
  input  logic [2:0]         child_slot,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  output logic               done,
  output logic [2:0]         status,
  output logic [11:0]        leaf_index,
  output logic [31:0]        node_color,
  output logic [4:0]         node_depth,
  output logic signed [15:0] node_x,
  output logic signed [15:0] node_y,
  output logic signed [15:0] node_z,
  output logic [11:0]        child_pointer,
  output logic [11:0]        nodes_used
);

  state_t             state;
  box_t               root_box;
  logic [COORD_W-1:0] min_size;
  logic [IDX_W-1:0]   idx, nf, cnt;
  logic [DEPTH_W-1:0] steps;
  box_t               box_r;
  logic               use_mem;
  op_t                op_r;
  pos_t               p_r;
  logic [COLOR_W-1:0] color_r;
  logic [2:0]         slot_r;

  logic               info_we, pos_we, box_we, child_we;
  logic [IDX_W-1:0]   info_wa, child_wa;
  info_t              info_wd, info_rd;
  pos_t               pos_rd;
  box_t               box_rd, cur_box;
  child_row_t         child_wd, child_rd;
  eval_t              ev;
  logic [IDX_W-1:0]   c, nf_inc;
  logic               leaf, need_alloc;

  svoi_ram #(.WIDTH($bits(info_t)), .DEPTH(POOL_NODES)) u_info (
    .clk, .we(info_we), .waddr(info_wa), .wdata(info_wd), .raddr(idx), .rdata(info_rd));
  svoi_ram #(.WIDTH($bits(pos_t)), .DEPTH(POOL_NODES)) u_pos (
    .clk, .we(pos_we), .waddr(state == S_INIT ? cnt : idx),
    .wdata(state == S_INIT ? pos_t'('0) : p_r), .raddr(idx), .rdata(pos_rd));
  svoi_ram #(.WIDTH($bits(box_t)), .DEPTH(POOL_NODES)) u_box (
    .clk, .we(box_we), .waddr(nf_inc), .wdata(ev.child_box), .raddr(idx), .rdata(box_rd));
  svoi_ram #(.WIDTH(CHILD_ROW_W), .DEPTH(POOL_NODES)) u_child (
    .clk, .we(child_we), .waddr(child_wa), .wdata(child_wd), .raddr(idx), .rdata(child_rd));

  assign cur_box = use_mem ? box_rd : box_r;

  svoi_eval u_eval (.bx(cur_box), .p(p_r), .min_size(min_size), .ev(ev));

  assign busy       = (state != S_IDLE);
  assign nf_inc     = nf + IDX_W'(1);
  assign c          = child_rd[ev.oct];
  assign leaf       = (info_rd.depth >= DEPTH_W'(DEPTH_LIMIT)) || ev.at_min ||
                      (steps >= DEPTH_W'(DEPTH_LIMIT));
  assign need_alloc = (c == '0);

  // Memory write control
  always_comb begin
    info_we  = 1'b0;
    pos_we   = 1'b0;
    box_we   = 1'b0;
    child_we = 1'b0;
    info_wa  = cnt;
    info_wd  = '{color: CLEAR_COLOR, depth: '0};
    child_wa = cnt;
    child_wd = '0;
    unique case (state)
      S_INIT: begin
        info_we  = 1'b1;
        pos_we   = 1'b1;
        child_we = 1'b1;
      end
      S_CLR: begin
        info_we  = 1'b1;
        child_we = 1'b1;
      end
      S_EV: begin
        if (op_r == OP_INSERT) begin
          if (leaf) begin
            info_we = 1'b1;
            pos_we  = 1'b1;
            info_wa = idx;
            info_wd = '{color: color_r, depth: info_rd.depth};
          end else if (ev.in_box && need_alloc && nf != LAST_NODE) begin
            info_we  = 1'b1;
            box_we   = 1'b1;
            child_we = 1'b1;
            info_wa  = nf_inc;
            info_wd  = '{color: PLACEHOLDER_BASE + COLOR_W'(ev.oct),
                         depth: info_rd.depth + DEPTH_W'(1)};
            child_wa = idx;
            child_wd = child_rd;
            child_wd[ev.oct] = nf_inc;
          end
        end
      end
      default: ;
    endcase
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      root_box <= '{xl: '0, xh: 16'sd1024, yl: '0, yh: 16'sd1024, zl: '0, zh: 16'sd1024};
      min_size <= 16'd1;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_X_LOW:  root_box.xl <= cfg_data;
        CFG_X_HIGH: root_box.xh <= cfg_data;
        CFG_Y_LOW:  root_box.yl <= cfg_data;
        CFG_Y_HIGH: root_box.yh <= cfg_data;
        CFG_Z_LOW:  root_box.zl <= cfg_data;
        CFG_Z_HIGH: root_box.zh <= cfg_data;
        CFG_MIN:    min_size    <= cfg_data;
        CFG_UNUSED: ;
      endcase
    end
  end

  // Sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      cnt   <= '0;
      nf    <= '0;
      done  <= 1'b0;
      idx   <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_INIT: begin
          cnt <= cnt + IDX_W'(1);
          if (cnt == LAST_NODE) state <= S_IDLE;
        end
        S_IDLE: begin
          if (start) begin
            op_r    <= op_t'(opcode);
            p_r     <= '{x: voxel_x, y: voxel_y, z: voxel_z};
            color_r <= voxel_color;
            slot_r  <= child_slot;
            box_r   <= root_box;
            use_mem <= 1'b0;
            steps   <= '0;
            cnt     <= '0;
            unique case (op_t'(opcode))
              OP_INSERT: begin idx <= '0;         state <= S_RD;  end
              OP_READ:   begin idx <= read_index; state <= S_RD;  end
              OP_CLEAR:  state <= S_CLR;
              OP_NONE:   ;
            endcase
          end
        end
        S_RD: state <= S_EV;
        S_EV: begin
          leaf_index    <= idx;
          node_color    <= info_rd.color;
          node_depth    <= info_rd.depth;
          node_x        <= pos_rd.x;
          node_y        <= pos_rd.y;
          node_z        <= pos_rd.z;
          child_pointer <= '0;
          nodes_used    <= nf;
          if (op_r != OP_INSERT) begin
            status        <= ST_READ_DONE;
            child_pointer <= child_rd[slot_r];
            done          <= 1'b1;
            state         <= S_IDLE;
          end else if (leaf) begin
            status     <= ST_STORED;
            node_color <= color_r;
            node_x     <= p_r.x;
            node_y     <= p_r.y;
            node_z     <= p_r.z;
            done       <= 1'b1;
            state      <= S_IDLE;
          end else if (!ev.in_box) begin
            status <= ST_OUTSIDE;
            done   <= 1'b1;
            state  <= S_IDLE;
          end else if (need_alloc && nf == LAST_NODE) begin
            status <= ST_POOL_FULL;
            done   <= 1'b1;
            state  <= S_IDLE;
          end else if (need_alloc) begin
            nf      <= nf_inc;
            idx     <= nf_inc;
            box_r   <= ev.child_box;
            use_mem <= 1'b0;
            steps   <= steps + DEPTH_W'(1);
            state   <= S_RD;
          end else begin
            // follow the existing child; its box comes from memory
            idx     <= c;
            box_r   <= cur_box;
            use_mem <= 1'b1;
            steps   <= steps + DEPTH_W'(1);
            state   <= S_RD;
          end
        end
        S_CLR: begin
          cnt <= cnt + IDX_W'(1);
          if (cnt == nf) begin
            nf            <= '0;
            status        <= ST_CLEARED;
            leaf_index    <= '0;
            node_color    <= '0;
            node_depth    <= '0;
            node_x        <= '0;
            node_y        <= '0;
            node_z        <= '0;
            child_pointer <= '0;
            nodes_used    <= '0;
            done          <= 1'b1;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_done_src: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(state) == S_EV || $past(state) == S_CLR))
    else $error("result without evaluate or clear");

  a_insert_reads: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && opcode == OP_INSERT) |=> (state == S_RD && idx == '0))
    else $error("insert did not start at root");

  a_clear_empty: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_CLEARED) |-> (nodes_used == '0 && nf == '0))
    else $error("clear left nodes in pool");

  a_alloc_step: assert property (@(posedge clk) disable iff (rst)
    (state == S_EV && nf != $past(nf)) |-> (nf == $past(nf) + IDX_W'(1)))
    else $error("pool grew by more than one");
`endif

endmodule

// ----- tb/sv/tb_sparse_voxel_octree_insert.sv -----
// Self-checking testbench for sparse_voxel_octree_insert: a queue-fed command driver,
// a result monitor and a behavioral octree model that predicts every result.
// Depends on svoi_pkg and the RTL of the block.
`timescale 1ns / 1ps

module tb_sparse_voxel_octree_insert;
  import svoi_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;

  typedef struct {
    op_t         op;
    logic [15:0] x, y, z;
    logic [31:0] color;
    logic [11:0] rd_idx;
    logic [2:0]  slot;
  } command_t;

  typedef struct {
    status_t     st;
    logic [11:0] leaf;
    logic [31:0] color;
    logic [4:0]  depth;
    logic [15:0] x, y, z;
    logic [11:0] child;
    logic [11:0] used;
  } outcome_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [1:0] opcode = '0;
  logic signed [15:0] voxel_x = '0, voxel_y = '0, voxel_z = '0;
  logic [31:0] voxel_color = '0;
  logic [11:0] read_index = '0;
  logic [2:0] child_slot = '0;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic done;
  logic [2:0] status;
  logic [11:0] leaf_index, child_pointer, nodes_used;
  logic [31:0] node_color;
  logic [4:0] node_depth;
  logic signed [15:0] node_x, node_y, node_z;

  sparse_voxel_octree_insert u_top (.*);

  always #6 clk = ~clk;

  // octree model state
  logic [11:0] tree_child [POOL_NODES*8];
  int          tree_lo [POOL_NODES][3];
  int          tree_hi [POOL_NODES][3];
  logic [31:0] tree_color [POOL_NODES];
  logic [4:0]  tree_depth [POOL_NODES];
  logic [15:0] tree_pos [POOL_NODES][3];
  int          tree_top;
  logic [15:0] box_reg [7];

  command_t pending_cmds [$];
  outcome_t expected_results [$];
  logic [15:0] visited [$];
  command_t cur;
  bit steady = 0;
  int mismatches = 0;
  int cycles = 0;

  function automatic void queue_cmd(command_t c);
    pending_cmds.insert(pending_cmds.size(), c);
  endfunction

  function automatic void expect_result(outcome_t r);
    expected_results.insert(expected_results.size(), r);
  endfunction

  function automatic outcome_t node_outcome(status_t st, int idx, logic [11:0] child);
    outcome_t r;
    r.st = st; r.leaf = 12'(idx); r.color = tree_color[idx]; r.depth = tree_depth[idx];
    r.x = tree_pos[idx][0]; r.y = tree_pos[idx][1]; r.z = tree_pos[idx][2];
    r.child = child; r.used = 12'(tree_top);
    return r;
  endfunction

  function automatic outcome_t octree_insert(command_t c);
    longint p[3], lo[3], hi[3], mid[3], e, lim;
    int idx, steps, slot, ch, k;
    bit leaf, in_box;
    logic [2:0] oct;
    idx = 0;
    lim = box_reg[CFG_MIN];
    p[0] = longint'($signed(c.x)); p[1] = longint'($signed(c.y));
    p[2] = longint'($signed(c.z));
    for (k = 0; k < 3; k++) begin
      lo[k] = longint'($signed(box_reg[2*k]));
      hi[k] = longint'($signed(box_reg[2*k+1]));
    end
    for (steps = 0; ; steps++) begin
      leaf = 1; in_box = 1;
      for (k = 0; k < 3; k++) begin
        e = hi[k] - lo[k];
        if (e < 0) e = -e;
        if (e > lim) leaf = 0;
        if (p[k] < lo[k] || p[k] > hi[k]) in_box = 0;
        mid[k] = (lo[k] + hi[k]) >>> 1;
      end
      if (tree_depth[idx] >= DEPTH_LIMIT || leaf || steps >= DEPTH_LIMIT) begin
        tree_color[idx] = c.color;
        for (k = 0; k < 3; k++) tree_pos[idx][k] = p[k][15:0];
        return node_outcome(ST_STORED, idx, '0);
      end
      if (!in_box) return node_outcome(ST_OUTSIDE, idx, '0);
      oct = {p[2] > mid[2], p[1] <= mid[1], p[0] > mid[0]};
      slot = idx * 8 + oct;
      ch = tree_child[slot];
      if (ch == 0) begin
        if (tree_top >= POOL_NODES - 1) return node_outcome(ST_POOL_FULL, idx, '0);
        tree_top++;
        ch = tree_top;
        tree_child[slot] = ch;
        // y is flipped: bit1 set takes the bottom half
        if (oct[0]) lo[0] = mid[0]; else hi[0] = mid[0];
        if (oct[1]) hi[1] = mid[1]; else lo[1] = mid[1];
        if (oct[2]) lo[2] = mid[2]; else hi[2] = mid[2];
        for (k = 0; k < 3; k++) begin
          tree_lo[ch][k] = lo[k]; tree_hi[ch][k] = hi[k];
        end
        tree_depth[ch] = tree_depth[idx] + 1;
        tree_color[ch] = PLACEHOLDER_BASE + oct;
      end else begin
        for (k = 0; k < 3; k++) begin
          lo[k] = tree_lo[ch][k]; hi[k] = tree_hi[ch][k];
        end
      end
      idx = ch;
    end
  endfunction

  function automatic void octree_apply(command_t c);
    outcome_t r;
    int i;
    case (c.op)
      OP_INSERT: expect_result(octree_insert(c));
      OP_CLEAR: begin
        for (i = 0; i <= tree_top; i++) begin
          tree_color[i] = CLEAR_COLOR;
          tree_depth[i] = '0;
          for (int s = 0; s < 8; s++) tree_child[i*8+s] = '0;
        end
        tree_top = 0;
        r = '{st: ST_CLEARED, default: '0};
        expect_result(r);
      end
      OP_READ: expect_result(
                 node_outcome(ST_READ_DONE, c.rd_idx, tree_child[c.rd_idx*8 + c.slot]));
      default: ;
    endcase
  endfunction

  // driver: hold the command while busy, advance on acceptance
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) octree_apply(cur);
      if (!(start && busy)) begin
        if (pending_cmds.size() > 0 && (steady || $urandom_range(99) >= 21)) begin
          cur = pending_cmds.pop_front();
          start <= 1'b1;
          opcode <= cur.op;
          voxel_x <= cur.x; voxel_y <= cur.y; voxel_z <= cur.z;
          voxel_color <= cur.color;
          read_index <= cur.rd_idx;
          child_slot <= cur.slot;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    outcome_t w, a;
    if (!rst && done) begin
      a = '{st: status_t'(status), leaf: leaf_index, color: node_color, depth: node_depth,
            x: node_x, y: node_y, z: node_z, child: child_pointer, used: nodes_used};
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transaction: status %0d", status);
      end else begin
        w = expected_results.pop_front();
        if (a != w) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp st%0d idx%0d col%0h d%0d (%0d,%0d,%0d) ch%0d u%0d / got st%0d idx%0d col%0h d%0d (%0d,%0d,%0d) ch%0d u%0d",
                     w.st, w.leaf, w.color, w.depth, $signed(w.x), $signed(w.y),
                     $signed(w.z), w.child, w.used, a.st, a.leaf, a.color, a.depth,
                     $signed(a.x), $signed(a.y), $signed(a.z), a.child, a.used);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic command_t make_cmd(op_t op, int x, int y, int z, logic [31:0] col,
                                        int rd, int s);
    command_t c;
    c.op = op; c.x = x; c.y = y; c.z = z; c.color = col; c.rd_idx = rd; c.slot = s;
    return c;
  endfunction

  function automatic logic [15:0] coord_in(int axis);
    int a, b, t;
    a = $signed(box_reg[2*axis]); b = $signed(box_reg[2*axis+1]);
    if (a > b) begin t = a; a = b; b = t; end
    return 16'(a + int'($urandom_range(b - a)));
  endfunction

  task automatic queue_random(int n, int clear_pct);
    command_t c;
    int r;
    repeat (n) begin
      r = $urandom_range(999);
      c = make_cmd(OP_INSERT, $urandom, $urandom, $urandom, $urandom,
                   $urandom_range(4095), $urandom_range(7));
      if (r < clear_pct * 10) c.op = OP_CLEAR;
      else if (r < 150) c.op = OP_READ;
      else if (r < 170) c.op = OP_NONE;
      else if (r < 270 && visited.size() >= 3) begin
        // revisit a stored point to walk existing branches
        r = $urandom_range(visited.size() / 3 - 1) * 3;
        c.x = visited[r]; c.y = visited[r+1]; c.z = visited[r+2];
      end else if (r < 900) begin
        c.x = coord_in(0); c.y = coord_in(1); c.z = coord_in(2);
        visited.insert(visited.size(), c.x);
        visited.insert(visited.size(), c.y);
        visited.insert(visited.size(), c.z);
        if (visited.size() > 300) repeat (3) void'(visited.pop_front());
      end
      if (c.op == OP_READ && $urandom_range(1)) c.rd_idx = $urandom_range(40);
      queue_cmd(c);
    end
  endtask

  task automatic drain;
    while (pending_cmds.size() > 0 || start || expected_results.size() > 0 || busy)
      @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t i, logic [15:0] v);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_index <= i; cfg_data <= v;
    box_reg[i] = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_box(int xl, int xh, int yl, int yh, int zl, int zh, int m);
    drain();
    write_reg(CFG_X_LOW, xl); write_reg(CFG_X_HIGH, xh);
    write_reg(CFG_Y_LOW, yl); write_reg(CFG_Y_HIGH, yh);
    write_reg(CFG_Z_LOW, zl); write_reg(CFG_Z_HIGH, zh);
    write_reg(CFG_MIN, m);
  endtask

  initial begin
    for (int i = 0; i < POOL_NODES; i++) begin
      tree_color[i] = CLEAR_COLOR; tree_depth[i] = '0;
      for (int k = 0; k < 3; k++) begin
        tree_pos[i][k] = '0; tree_lo[i][k] = 0; tree_hi[i][k] = 0;
      end
    end
    foreach (tree_child[i]) tree_child[i] = '0;
    tree_top = 0;
    box_reg = '{16'd0, 16'd1024, 16'd0, 16'd1024, 16'd0, 16'd1024, 16'd1};
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // corners, midpoints, outside points, reads, clear and the unused opcode
    queue_cmd(make_cmd(OP_READ, 0, 0, 0, 0, 0, 0));
    queue_cmd(make_cmd(OP_INSERT, 0, 0, 0, 32'h0, 0, 0));
    queue_cmd(make_cmd(OP_INSERT, 1024, 1024, 1024, 32'hFFFF_FFFF, 0, 0));
    queue_cmd(make_cmd(OP_INSERT, 512, 512, 512, 32'h1234_5678, 0, 0));
    queue_cmd(make_cmd(OP_INSERT, 513, 511, 513, 32'h8765_4321, 0, 0));
    queue_cmd(make_cmd(OP_INSERT, -1, 5, 5, 32'hA5A5_A5A5, 0, 0));
    queue_cmd(make_cmd(OP_INSERT, 5, 1025, 5, 1, 0, 0));
    queue_cmd(make_cmd(OP_INSERT, -32768, 32767, -32768, 2, 0, 0));
    queue_cmd(make_cmd(OP_NONE, 3, 3, 3, 3, 1, 1));
    for (int s = 0; s < 8; s++) queue_cmd(make_cmd(OP_READ, 0, 0, 0, 0, 0, s));
    queue_cmd(make_cmd(OP_READ, 0, 0, 0, 0, 1, 7));
    queue_cmd(make_cmd(OP_READ, 0, 0, 0, 0, 4095, 7));
    queue_cmd(make_cmd(OP_CLEAR, 0, 0, 0, 0, 0, 0));
    queue_cmd(make_cmd(OP_READ, 0, 0, 0, 0, 1, 0));
    queue_cmd(make_cmd(OP_INSERT, 1024, 0, 1024, 9, 0, 0));

    // dense default box with no clears, enough to exhaust the pool
    queue_random(650, 0);
    drain();
    queue_cmd(make_cmd(OP_CLEAR, 0, 0, 0, 0, 0, 0));

    // full coordinate range, no size floor: descent runs to the depth limit
    set_box(-32768, 32767, -32768, 32767, -32768, 32767, 0);
    steady = 1;
    queue_random(400, 2);
    drain();
    steady = 0;

    // root already a leaf, reversed box
    set_box(100, -100, 32767, -32768, 0, 0, 65535);
    queue_random(100, 2);

    // small odd box
    set_box(-64, 63, -7, 120, -100, -3, 3);
    queue_random(450, 1);

    set_box(0, 1024, 0, 1024, 0, 1024, 1);
    queue_random(300, 1);
    drain();

    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
